// ----- src/rasr_pkg.sv -----
// rasr_pkg: shared widths, mode and status codes for the rational unit
// no dependencies
package rasr_pkg;

    localparam int DW = 32;
    localparam int WW = 2 * DW;

    localparam logic [1:0] MODE_NORM = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_SUB  = 2'd2;
    localparam logic [1:0] MODE_EQ   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic          neg;
        logic [WW-1:0] mag;
        logic [WW-1:0] den;
    } frac_t;

endpackage

// ----- src/rasr_div.sv -----
// rasr_div: restoring divider, one quotient bit per cycle
// depends on rasr_pkg
module rasr_div
    import rasr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [WW-1:0] dividend,
    input  logic [WW-1:0] divisor,
    output logic          done,
    output logic [WW-1:0] quot,
    output logic [WW-1:0] rem
);

    localparam int CW = $clog2(WW);

    logic          run_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [WW-1:0] rem_reg;
    logic [WW-1:0] quo_reg;
    logic [WW-1:0] div_reg;
    logic [WW:0]   shifted;
    logic [WW:0]   diff;

    assign shifted = {rem_reg, quo_reg[WW-1]};
    assign diff    = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(WW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (!diff[WW])
            begin
                rem_reg <= diff[WW-1:0];
                quo_reg <= {quo_reg[WW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[WW-1:0];
                quo_reg <= {quo_reg[WW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- src/rasr_mul.sv -----
// rasr_mul: shift-add multiplier, one multiplier bit per cycle
// depends on rasr_pkg
module rasr_mul
    import rasr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] op_a,
    input  logic [DW-1:0] op_b,
    output logic          done,
    output logic [WW-1:0] product
);

    localparam int CW = $clog2(DW);

    logic          run_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [WW-1:0] acc_reg;
    logic [WW-1:0] mcand_reg;
    logic [DW-1:0] mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= WW'(op_a);
            mplier_reg <= op_b;
        end
        else if (run_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[WW-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[DW-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- src/rational_add_sub_reduce.sv -----
// rational_add_sub_reduce: rational normalize / add / subtract / equality unit
// depends on rasr_pkg, rasr_div, rasr_mul
//
// channel   signals                                            direction
// command   start, busy, mode, first_num/den, second_num/den   in (busy out)
// result    done, result_num, result_den, is_equal, status     out
//
// one item at a time; busy stays high until its result is strobed
// each gcd step and each reduction division runs on the shared divider
// an item runs its gcd steps and two divisions per reduction, plus three products in add/sub modes
// rst_n clears the sequencer; result held until the next start, done high for one cycle, receiver cannot stall
module rational_add_sub_reduce
    import rasr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic signed [31:0] first_num,
    input  logic signed [31:0] first_den,
    input  logic signed [31:0] second_num,
    input  logic signed [31:0] second_den,
    output logic               done,
    output logic signed [31:0] result_num,
    output logic [30:0]        result_den,
    output logic               is_equal,
    output logic [1:0]         status
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RED  = 4'd1;
    localparam logic [3:0] S_GCD  = 4'd2;
    localparam logic [3:0] S_GCDW = 4'd3;
    localparam logic [3:0] S_DM   = 4'd4;
    localparam logic [3:0] S_DMW  = 4'd5;
    localparam logic [3:0] S_DD   = 4'd6;
    localparam logic [3:0] S_DDW  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_MP   = 4'd9;
    localparam logic [3:0] S_MPW  = 4'd10;
    localparam logic [3:0] S_MQ   = 4'd11;
    localparam logic [3:0] S_MQW  = 4'd12;
    localparam logic [3:0] S_MD   = 4'd13;
    localparam logic [3:0] S_MDW  = 4'd14;
    localparam logic [3:0] S_CHK  = 4'd15;

    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_R = 2'd2;

    localparam logic [WW-1:0] LIMIT = WW'((64'd1 << (DW - 1)) - 64'd1);

    logic [3:0]    state_reg;
    logic [1:0]    phase_reg;
    logic [1:0]    mode_reg;
    logic [DW-1:0] bn_reg;
    logic [DW-1:0] bd_reg;
    frac_t         red_reg;
    frac_t         a_reg;
    frac_t         b_reg;
    logic [WW-1:0] gx_reg;
    logic [WW-1:0] gy_reg;
    logic [WW-1:0] p_reg;
    logic [WW-1:0] q_reg;

    logic          done_reg;
    logic [31:0]   onum_reg;
    logic [30:0]   oden_reg;
    logic          eq_reg;
    logic [1:0]    st_reg;

    logic          div_start;
    logic [WW-1:0] div_a;
    logic [WW-1:0] div_b;
    logic          div_done;
    logic [WW-1:0] div_q;
    logic [WW-1:0] div_r;
    logic          mul_start;
    logic [DW-1:0] mul_a;
    logic [DW-1:0] mul_b;
    logic          mul_done;
    logic [WW-1:0] mul_p;

    logic          an_neg;
    logic          ad_neg;
    logic          bn_neg;
    logic          bd_neg;
    logic [WW-1:0] an_mag;
    logic [WW-1:0] ad_mag;
    logic [WW-1:0] bn_mag;
    logic [WW-1:0] bd_mag;
    logic          qn;
    frac_t         sum;
    logic [WW-1:0] onum_w;

    function automatic logic [WW-1:0] mag_of(input logic [DW-1:0] v);
        logic [WW-1:0] ext;
        ext = WW'(signed'(v));
        return v[DW-1] ? (WW'(0) - ext) : ext;
    endfunction

    assign an_neg = first_num[DW-1];
    assign ad_neg = first_den[DW-1];
    assign bn_neg = bn_reg[DW-1];
    assign bd_neg = bd_reg[DW-1];
    assign an_mag = mag_of(first_num[DW-1:0]);
    assign ad_mag = mag_of(first_den[DW-1:0]);
    assign bn_mag = mag_of(bn_reg);
    assign bd_mag = mag_of(bd_reg);

    rasr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    rasr_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // gcd step divides gx by gy, reduction divides by the gcd left in gx
    always_comb
    begin
        div_start = 1'b0;
        div_a     = red_reg.mag;
        div_b     = gx_reg;
        case (state_reg)
            S_GCD:
            begin
                div_start = (gy_reg != '0);
                div_a     = gx_reg;
                div_b     = gy_reg;
            end
            S_DM:
            begin
                div_start = 1'b1;
                div_a     = red_reg.mag;
            end
            S_DD:
            begin
                div_start = 1'b1;
                div_a     = red_reg.den;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = a_reg.mag[DW-1:0];
        mul_b     = b_reg.den[DW-1:0];
        case (state_reg)
            S_MP:
            begin
                mul_start = 1'b1;
            end
            S_MQ:
            begin
                mul_start = 1'b1;
                mul_a     = b_reg.mag[DW-1:0];
                mul_b     = a_reg.den[DW-1:0];
            end
            S_MD:
            begin
                mul_start = 1'b1;
                mul_a     = a_reg.den[DW-1:0];
                mul_b     = b_reg.den[DW-1:0];
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        qn  = (mode_reg == MODE_SUB) ? !b_reg.neg : b_reg.neg;
        sum = '0;
        sum.den = mul_p;
        if (a_reg.neg == qn)
        begin
            sum.neg = a_reg.neg;
            sum.mag = p_reg + q_reg;
        end
        else if (p_reg >= q_reg)
        begin
            sum.neg = a_reg.neg;
            sum.mag = p_reg - q_reg;
        end
        else
        begin
            sum.neg = qn;
            sum.mag = q_reg - p_reg;
        end
    end

    assign onum_w = red_reg.neg ? (WW'(0) - red_reg.mag) : red_reg.mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_A;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= PH_A;
                        if (ad_mag == '0 ||
                            (mode != MODE_NORM && second_den[DW-1:0] == '0))
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_RED;
                        end
                    end
                end
                S_RED:
                begin
                    state_reg <= (red_reg.mag == '0) ? S_FIN : S_GCD;
                end
                S_GCD:
                begin
                    state_reg <= (gy_reg == '0) ? S_DM : S_GCDW;
                end
                S_GCDW:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_GCD;
                    end
                end
                S_DM:
                begin
                    state_reg <= S_DMW;
                end
                S_DMW:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DD;
                    end
                end
                S_DD:
                begin
                    state_reg <= S_DDW;
                end
                S_DDW:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    case (phase_reg)
                        PH_A:
                        begin
                            if (mode_reg == MODE_NORM)
                            begin
                                state_reg <= S_CHK;
                            end
                            else
                            begin
                                phase_reg <= PH_B;
                                state_reg <= S_RED;
                            end
                        end
                        PH_B:
                        begin
                            if (mode_reg == MODE_EQ)
                            begin
                                done_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_MP;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_CHK;
                        end
                    endcase
                end
                S_MP:
                begin
                    state_reg <= S_MPW;
                end
                S_MPW:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_MQ;
                    end
                end
                S_MQ:
                begin
                    state_reg <= S_MQW;
                end
                S_MQW:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_MD;
                    end
                end
                S_MD:
                begin
                    state_reg <= S_MDW;
                end
                S_MDW:
                begin
                    if (mul_done)
                    begin
                        phase_reg <= PH_R;
                        state_reg <= S_RED;
                    end
                end
                S_CHK:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_reg    <= mode;
                    bn_reg      <= second_num[DW-1:0];
                    bd_reg      <= second_den[DW-1:0];
                    red_reg.neg <= an_neg != ad_neg;
                    red_reg.mag <= an_mag;
                    red_reg.den <= ad_mag;
                    onum_reg    <= '0;
                    oden_reg    <= 31'd1;
                    eq_reg      <= 1'b0;
                    st_reg      <= ST_ZDEN;
                end
            end
            S_RED:
            begin
                gx_reg <= red_reg.mag;
                gy_reg <= red_reg.den;
                if (red_reg.mag == '0)
                begin
                    red_reg.neg <= 1'b0;
                    red_reg.den <= WW'(1);
                end
            end
            S_GCD:
            begin
                if (gy_reg != '0)
                begin
                    gx_reg <= gy_reg;
                    gy_reg <= gx_reg;
                end
            end
            S_GCDW:
            begin
                if (div_done)
                begin
                    gy_reg <= div_r;
                end
            end
            S_DMW:
            begin
                if (div_done)
                begin
                    red_reg.mag <= div_q;
                end
            end
            S_DDW:
            begin
                if (div_done)
                begin
                    red_reg.den <= div_q;
                end
            end
            S_FIN:
            begin
                case (phase_reg)
                    PH_A:
                    begin
                        a_reg <= red_reg;
                        if (mode_reg != MODE_NORM)
                        begin
                            red_reg.neg <= bn_neg != bd_neg;
                            red_reg.mag <= bn_mag;
                            red_reg.den <= bd_mag;
                        end
                    end
                    PH_B:
                    begin
                        b_reg  <= red_reg;
                        eq_reg <= (mode_reg == MODE_EQ) && (a_reg == red_reg);
                        st_reg <= ST_OK;
                    end
                    default:
                    begin
                        st_reg <= ST_OK;
                    end
                endcase
            end
            S_MPW:
            begin
                if (mul_done)
                begin
                    p_reg <= mul_p;
                end
            end
            S_MQW:
            begin
                if (mul_done)
                begin
                    q_reg <= mul_p;
                end
            end
            S_MDW:
            begin
                if (mul_done)
                begin
                    red_reg <= sum;
                end
            end
            S_CHK:
            begin
                if (red_reg.mag > LIMIT || red_reg.den > LIMIT)
                begin
                    st_reg <= ST_OVF;
                end
                else
                begin
                    st_reg   <= ST_OK;
                    onum_reg <= 32'(signed'(onum_w[DW-1:0]));
                    oden_reg <= 31'(red_reg.den[DW-2:0]);
                end
            end
            default:
            begin
                gx_reg <= gx_reg;
            end
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign result_num = onum_reg;
    assign result_den = oden_reg;
    assign is_equal   = eq_reg;
    assign status     = st_reg;

endmodule
